FILE: hdl/tcst_pkg.sv
// ----------------------------------------------------------------------------
// tcst_pkg: shared types and constants of the touch contact slot tracker
// Request codes, decoded operations, slot key states, status codes and the
// transaction structs passed between the front end, queue and slot engine.
// ----------------------------------------------------------------------------
package tcst_pkg;

    // Default sizes
    localparam int NUM_SLOTS_DEF = 8;
    localparam int ID_BITS_DEF   = 16;
    localparam int CMD_DEPTH_DEF = 2;

    // Fixed port widths
    localparam int REQ_W = 3;
    localparam int ID_W  = 16;
    localparam int POS_W = 16;
    localparam int IDX_W = 4;

    // Request codes on req_type
    localparam logic [REQ_W-1:0] REQ_AGE    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MOVE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_END    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REPORT = 3'd4;

    typedef enum logic [2:0] {
        OP_AGE,
        OP_START,
        OP_MOVE,
        OP_END,
        OP_REPORT,
        OP_UNKNOWN
    } op_t;

    typedef enum logic [1:0] {
        KEY_IDLE,
        KEY_DOWN,
        KEY_HELD,
        KEY_UP
    } key_state_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_FREE,
        ST_NOT_FOUND,
        ST_UNKNOWN
    } status_t;

    typedef enum logic {
        BS_IDLE,
        BS_REPORT
    } back_state_t;

    // Classified request, front end to slot engine
    typedef struct packed {
        op_t                     op;
        logic [ID_W-1:0]         contact_id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } cmd_t;

    // One result transaction
    typedef struct packed {
        logic [IDX_W-1:0]        slot_index;
        key_state_t              key_state;
        logic signed [POS_W-1:0] slot_x;
        logic signed [POS_W-1:0] slot_y;
        status_t                 status;
        logic                    last;
    } res_t;

    // Map a raw request code onto an operation
    function automatic op_t decode_req(input logic [REQ_W-1:0] req);
        op_t op;
        case (req)
            REQ_AGE:    op = OP_AGE;
            REQ_START:  op = OP_START;
            REQ_MOVE:   op = OP_MOVE;
            REQ_END:    op = OP_END;
            REQ_REPORT: op = OP_REPORT;
            default:    op = OP_UNKNOWN;
        endcase
        return op;
    endfunction

endpackage

FILE: hdl/tcst_front.sv
// ----------------------------------------------------------------------------
// tcst_front: request intake
// Accepts request transactions, decodes the request type and holds the
// classified command until the command queue takes it.
// ----------------------------------------------------------------------------
module tcst_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [tcst_pkg::REQ_W-1:0]        req_type,
    input  logic [tcst_pkg::ID_W-1:0]         contact_id,
    input  logic signed [tcst_pkg::POS_W-1:0] pos_x,
    input  logic signed [tcst_pkg::POS_W-1:0] pos_y,
    output logic                              cmd_valid,
    output tcst_pkg::cmd_t                    cmd,
    input  logic                              cmd_ready
);

    logic           valid_reg;
    logic           valid_next;
    tcst_pkg::cmd_t cmd_reg;
    logic           accept;
    logic           moved;

    // Handshake
    assign moved      = valid_reg && cmd_ready;
    assign full       = valid_reg && !cmd_ready;
    assign accept     = push && !full;
    assign valid_next = accept || (valid_reg && !moved);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Classified command
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.op         <= tcst_pkg::decode_req(req_type);
            cmd_reg.contact_id <= contact_id;
            cmd_reg.pos_x      <= pos_x;
            cmd_reg.pos_y      <= pos_y;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

FILE: hdl/tcst_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tcst_cmd_fifo: command queue
// Short register queue between the request front end and the slot engine.
// ----------------------------------------------------------------------------
module tcst_cmd_fifo #(
    parameter int DEPTH = tcst_pkg::CMD_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tcst_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           pop,
    output tcst_pkg::cmd_t rd_data,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    tcst_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hdl/tcst_back.sv
// ----------------------------------------------------------------------------
// tcst_back: slot engine
// Holds the slot table and carries out queued commands: aging, claiming a
// free slot, updating a matched contact and walking the table for a report.
// Results leave through a one-entry output register.
// ----------------------------------------------------------------------------
module tcst_back #(
    parameter int NUM_SLOTS = tcst_pkg::NUM_SLOTS_DEF,
    parameter int ID_BITS   = tcst_pkg::ID_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  tcst_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           res_valid,
    output tcst_pkg::res_t res,
    input  logic           res_pop
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CMP_W  = (ID_BITS < tcst_pkg::ID_W) ? ID_BITS : tcst_pkg::ID_W;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    // Slot table
    tcst_pkg::key_state_t               key_reg     [NUM_SLOTS];
    tcst_pkg::key_state_t               key_next    [NUM_SLOTS];
    logic [ID_BITS-1:0]                 contact_reg [NUM_SLOTS];
    logic signed [tcst_pkg::POS_W-1:0]  px_reg      [NUM_SLOTS];
    logic signed [tcst_pkg::POS_W-1:0]  py_reg      [NUM_SLOTS];

    // Control
    tcst_pkg::back_state_t state_reg;
    tcst_pkg::back_state_t state_next;
    logic [SLOT_W-1:0]     idx_reg;
    logic [SLOT_W-1:0]     idx_next;
    tcst_pkg::res_t        res_reg;
    tcst_pkg::res_t        res_next;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    logic                  res_load;
    logic                  out_free;

    // Slot write port
    logic              slot_we;
    logic [SLOT_W-1:0] slot_wr_idx;

    // Search results
    logic [ID_BITS-1:0] cid_m;
    logic               free_hit;
    logic [SLOT_W-1:0]  free_idx;
    logic               match_hit;
    logic [SLOT_W-1:0]  match_idx;
    logic               any_released;

    // Stored identifier: low ID_BITS of the contact, zero above the port width
    always_comb
    begin
        cid_m = '0;
        cid_m[CMP_W-1:0] = cmd.contact_id[CMP_W-1:0];
    end

    // Lowest free slot and lowest matching live slot
    always_comb
    begin
        free_hit     = 1'b0;
        free_idx     = '0;
        match_hit    = 1'b0;
        match_idx    = '0;
        any_released = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (key_reg[i] == tcst_pkg::KEY_IDLE)
            begin
                free_hit = 1'b1;
                free_idx = SLOT_W'(i);
            end
            if ((key_reg[i] == tcst_pkg::KEY_DOWN || key_reg[i] == tcst_pkg::KEY_HELD)
                && contact_reg[i] == cid_m)
            begin
                match_hit = 1'b1;
                match_idx = SLOT_W'(i);
            end
            if (key_reg[i] == tcst_pkg::KEY_UP)
            begin
                any_released = 1'b1;
            end
        end
    end

    assign out_free = !res_valid_reg || res_pop;

    // Command sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        res_load       = 1'b0;
        cmd_pop        = 1'b0;
        slot_we        = 1'b0;
        slot_wr_idx    = '0;

        case (state_reg)
            tcst_pkg::BS_IDLE:
            begin
                if (cmd_valid && (out_free || cmd.op == tcst_pkg::OP_AGE))
                begin
                    cmd_pop             = 1'b1;
                    res_next.slot_index = '0;
                    res_next.key_state  = tcst_pkg::KEY_IDLE;
                    res_next.slot_x     = '0;
                    res_next.slot_y     = '0;
                    res_next.status     = tcst_pkg::ST_OK;
                    res_next.last       = 1'b1;
                    case (cmd.op)
                        tcst_pkg::OP_AGE:
                        begin
                            for (int i = 0; i < NUM_SLOTS; i++)
                            begin
                                if (key_reg[i] == tcst_pkg::KEY_UP)
                                begin
                                    key_next[i] = tcst_pkg::KEY_IDLE;
                                end
                                else if (key_reg[i] == tcst_pkg::KEY_DOWN)
                                begin
                                    key_next[i] = tcst_pkg::KEY_HELD;
                                end
                            end
                        end
                        tcst_pkg::OP_START:
                        begin
                            res_load = 1'b1;
                            if (free_hit)
                            begin
                                slot_we               = 1'b1;
                                slot_wr_idx           = free_idx;
                                key_next[free_idx]    = tcst_pkg::KEY_DOWN;
                                res_next.slot_index   = tcst_pkg::IDX_W'(free_idx);
                                res_next.key_state    = tcst_pkg::KEY_DOWN;
                                res_next.slot_x       = cmd.pos_x;
                                res_next.slot_y       = cmd.pos_y;
                            end
                            else
                            begin
                                res_next.status = tcst_pkg::ST_NO_FREE;
                            end
                        end
                        tcst_pkg::OP_MOVE, tcst_pkg::OP_END:
                        begin
                            res_load = 1'b1;
                            if (match_hit)
                            begin
                                slot_we             = 1'b1;
                                slot_wr_idx         = match_idx;
                                key_next[match_idx] = (cmd.op == tcst_pkg::OP_MOVE) ?
                                                      tcst_pkg::KEY_HELD :
                                                      tcst_pkg::KEY_UP;
                                res_next.slot_index = tcst_pkg::IDX_W'(match_idx);
                                res_next.key_state  = key_next[match_idx];
                                res_next.slot_x     = cmd.pos_x;
                                res_next.slot_y     = cmd.pos_y;
                            end
                            else
                            begin
                                res_next.status = tcst_pkg::ST_NOT_FOUND;
                            end
                        end
                        tcst_pkg::OP_REPORT:
                        begin
                            res_load           = 1'b1;
                            res_next.key_state = key_reg[0];
                            res_next.slot_x    = px_reg[0];
                            res_next.slot_y    = py_reg[0];
                            res_next.last      = (LAST_IDX == '0);
                            if (LAST_IDX != '0)
                            begin
                                state_next = tcst_pkg::BS_REPORT;
                                idx_next   = SLOT_W'(1);
                            end
                        end
                        default:
                        begin
                            res_load        = 1'b1;
                            res_next.status = tcst_pkg::ST_UNKNOWN;
                        end
                    endcase
                end
            end
            tcst_pkg::BS_REPORT:
            begin
                if (out_free)
                begin
                    res_load            = 1'b1;
                    res_next.slot_index = tcst_pkg::IDX_W'(idx_reg);
                    res_next.key_state  = key_reg[idx_reg];
                    res_next.slot_x     = px_reg[idx_reg];
                    res_next.slot_y     = py_reg[idx_reg];
                    res_next.status     = tcst_pkg::ST_OK;
                    res_next.last       = (idx_reg == LAST_IDX);
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = tcst_pkg::BS_IDLE;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = SLOT_W'(idx_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = tcst_pkg::BS_IDLE;
                idx_next   = '0;
            end
        endcase

        res_valid_next = res_load || (res_valid_reg && !res_pop);
    end

    // Control, key state and position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcst_pkg::BS_IDLE;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                key_reg[i] <= tcst_pkg::KEY_IDLE;
                px_reg[i]  <= '0;
                py_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
            key_reg       <= key_next;
            if (slot_we)
            begin
                px_reg[slot_wr_idx] <= cmd.pos_x;
                py_reg[slot_wr_idx] <= cmd.pos_y;
            end
        end
    end

    // Contact identifiers, written only on a start
    always_ff @(posedge clk)
    begin
        if (slot_we && cmd.op == tcst_pkg::OP_START)
        begin
            contact_reg[slot_wr_idx] <= cid_m;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Checks
    a_report_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tcst_pkg::BS_REPORT |-> (idx_reg != '0 && idx_reg <= LAST_IDX))
        else $error("report walk index out of range");

    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result register overwritten while occupied");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == tcst_pkg::BS_IDLE && cmd_valid))
        else $error("command taken outside idle or from an empty queue");

    a_age_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd.op == tcst_pkg::OP_AGE) |=> !any_released)
        else $error("released slot survived an age transaction");

    a_report_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcst_pkg::BS_REPORT && res_load && idx_reg == LAST_IDX)
        |=> state_reg == tcst_pkg::BS_IDLE)
        else $error("report walk did not end after the last slot");

endmodule

FILE: hdl/touch_contact_slot_tracker.sv
// ----------------------------------------------------------------------------
// touch_contact_slot_tracker: multitouch contact slot table
// Tracks touch contacts in a fixed table of slots and reports slot contents.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   request  | push / full        | req_type, contact_id, pos_x, pos_y
//   result   | pop / empty        | slot_index, key_state, slot_x, slot_y,
//            |                    | status, last
//
// A request transaction is decoded in the front end and queued; the slot
// engine takes one command per cycle while idle and once its output
// register is free (an age needs no room there). A report keeps the engine
// busy while it walks the table, one slot per cycle through the single
// output register whenever that register is free. A result passes the
// front end register, command queue and output register on its way out.
// Reset clears all slots to inactive with zero position; no clearing pass.
// A held result stalls the engine, the queue then fills and full rises.
// ----------------------------------------------------------------------------
module touch_contact_slot_tracker #(
    parameter int NUM_SLOTS = tcst_pkg::NUM_SLOTS_DEF,
    parameter int ID_BITS   = tcst_pkg::ID_BITS_DEF,
    parameter int CMD_DEPTH = tcst_pkg::CMD_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [tcst_pkg::REQ_W-1:0]        req_type,
    input  logic [tcst_pkg::ID_W-1:0]         contact_id,
    input  logic signed [tcst_pkg::POS_W-1:0] pos_x,
    input  logic signed [tcst_pkg::POS_W-1:0] pos_y,
    output logic                              empty,
    input  logic                              pop,
    output logic [tcst_pkg::IDX_W-1:0]        slot_index,
    output logic [1:0]                        key_state,
    output logic signed [tcst_pkg::POS_W-1:0] slot_x,
    output logic signed [tcst_pkg::POS_W-1:0] slot_y,
    output logic [1:0]                        status,
    output logic                              last
);

    logic           fr_valid;
    tcst_pkg::cmd_t fr_cmd;
    logic           q_full;
    logic           q_empty;
    tcst_pkg::cmd_t q_cmd;
    logic           q_pop;
    logic           res_valid;
    tcst_pkg::res_t res;

    // Request intake
    tcst_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .contact_id (contact_id),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .cmd_valid  (fr_valid),
        .cmd        (fr_cmd),
        .cmd_ready  (!q_full)
    );

    // Command queue
    tcst_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fr_valid),
        .wr_data (fr_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_cmd),
        .empty   (q_empty)
    );

    // Slot engine
    tcst_back #(
        .NUM_SLOTS (NUM_SLOTS),
        .ID_BITS   (ID_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    // Result ports
    assign empty      = !res_valid;
    assign slot_index = res.slot_index;
    assign key_state  = res.key_state;
    assign slot_x     = res.slot_x;
    assign slot_y     = res.slot_y;
    assign status     = res.status;
    assign last       = res.last;

endmodule
